// ===== sv/mftd_pkg.sv =====
// Shared types and constants for the minimum-finish task dispatcher.
`default_nettype none

package mftd_pkg;

   // Number of servers held in the dispatcher.
   localparam int MAX_SERVERS = 8;

   // Width of a slot index inside the dispatcher.
   localparam int SRV_IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

   // The server index field is 3 bits wide, so at most eight servers can be enabled.
   localparam int INDEX_LIMIT = 8;
   localparam int ENABLE_LIMIT = (MAX_SERVERS < INDEX_LIMIT) ? MAX_SERVERS : INDEX_LIMIT;

   // Field widths of the request and the response.
   localparam int MODE_W   = 1;
   localparam int INDEX_W  = 3;
   localparam int TIME_W   = 16;
   localparam int TASKS_W  = 16;
   localparam int FINISH_W = 32;
   localparam int COUNT_W  = 4;

   // Saturation point of a server's task count.
   localparam logic [TASKS_W-1:0] TASK_MAX = '1;

   // Server count after reset.
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_LOAD   = 1'b0;
   localparam logic [MODE_W-1:0] MODE_ASSIGN = 1'b1;

   // One server as seen by the arg-min tree.
   typedef struct packed {
      logic                 valid;
      logic [SRV_IDX_W-1:0] index;
      logic [TIME_W-1:0]    task_time;
      logic [TASKS_W-1:0]   tasks;
      logic [FINISH_W-1:0]  finish;
   } cand_type;

endpackage

`default_nettype wire

// ===== sv/mftd_argmin.sv =====
// Arg-min tree that picks the enabled server with the least finish time after one more task.
`default_nettype none

module mftd_argmin
   import mftd_pkg::*;
(
   input  cand_type leaf   [MAX_SERVERS],
   output cand_type winner
);

   localparam int SLOTS = 1 << SRV_IDX_W;
   localparam int NODES = 2 * SLOTS - 1;

   cand_type node [NODES];

   // Pick the better of two candidates. On a full tie the left one, which has the lower index, wins.
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type r;
      r = a;
      if (!a.valid) begin
         r = b;
      end else if (b.valid) begin
         if ((b.finish < a.finish) ||
             ((b.finish == a.finish) && (b.task_time < a.task_time))) begin
            r = b;
         end
      end
      return r;
   endfunction

   // Leaves hold the servers in index order. Padding slots never win.
   // Each inner node compares its two children. There are SRV_IDX_W levels.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         if (i < MAX_SERVERS) begin
            node[SLOTS-1+i] = leaf[i];
         end else begin
            node[SLOTS-1+i] = '0;
         end
      end
      for (int n = SLOTS - 2; n >= 0; n--) begin
         node[n] = pick(node[2*n+1], node[2*n+2]);
      end
   end

   assign winner = node[0];

endmodule

`default_nettype wire

// ===== sv/min_finish_task_dispatcher.sv =====
// Top level of the minimum-finish task dispatcher: greedy list scheduling over up to eight servers.
//
// Usage:
// A request with req_mode at zero loads the per-task time of one server and clears that
// server's task count. A request with req_mode at one assigns one task. The task goes to the
// enabled server with the least (count+1)*time. A tie goes to the smaller task time and then
// to the lower index. One response reports the server, its new count and its finish time.
// A load request, and an assign request while zero servers are enabled, give no response.
// The enabled servers are indices 0 to csr_server_count-1; a count above eight acts as eight.
// The register is written through csr_valid and csr_ready, and csr_ready is always high.
// Write it only while the block is idle. Throughput is one request per cycle while req_stall
// is low. A request goes into an input register, where the arg-min tree and the state update
// work on it, and its response is written to the output register as the request leaves it.
// Finish times are kept per server as running sums, so the block needs no multiplier.
// While rsp_stall holds a pending response, a load request still passes through. An assign
// request that yields a response waits in the input register, and req_stall rises behind it.
// A synchronous reset sets the server count to 2, clears all task counts and empties both
// registers. Task times are undefined until a load request writes them.

`default_nettype none

module min_finish_task_dispatcher
   import mftd_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [COUNT_W-1:0]   csr_server_count,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [MODE_W-1:0]    req_mode,
   input  wire  [INDEX_W-1:0]   req_server_index,
   input  wire  [TIME_W-1:0]    req_task_time,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [INDEX_W-1:0]   rsp_chosen_server,
   output logic [TASKS_W-1:0]   rsp_task_total,
   output logic [FINISH_W-1:0]  rsp_finish_time
);

   // Configuration and per-server state.
   logic [COUNT_W-1:0]  count_ff;
   logic [TIME_W-1:0]   time_ff   [MAX_SERVERS];
   logic [TASKS_W-1:0]  tasks_ff  [MAX_SERVERS];
   logic [FINISH_W-1:0] finish_ff [MAX_SERVERS];

   // Input register.
   logic                stage_valid_ff;
   logic [MODE_W-1:0]   stage_mode_ff;
   logic [INDEX_W-1:0]  stage_index_ff;
   logic [TIME_W-1:0]   stage_time_ff;
   logic                stage_valid_in;

   // Output register.
   logic                out_valid_ff;
   logic [INDEX_W-1:0]  out_server_ff;
   logic [TASKS_W-1:0]  out_total_ff;
   logic [FINISH_W-1:0] out_finish_ff;
   logic                out_valid_in;
   logic [INDEX_W-1:0]  out_server_in;
   logic [TASKS_W-1:0]  out_total_in;
   logic [FINISH_W-1:0] out_finish_in;

   // Combinational work for the request in the input register.
   logic [COUNT_W-1:0]   n_enabled;
   cand_type             leaf [MAX_SERVERS];
   cand_type             winner;
   logic                 is_load;
   logic                 load_hit;
   logic [SRV_IDX_W-1:0] load_slot;
   logic                 has_result;
   logic                 out_free;
   logic                 advance;
   logic                 saturated;
   logic [TASKS_W-1:0]   count_in;
   logic [FINISH_W-1:0]  finish_in;
   logic [FINISH_W-1:0]  report_finish;

   assign csr_ready = 1'b1;

   // The enabled count saturates at the number of servers that exist.
   always_comb begin
      if (count_ff > COUNT_W'(ENABLE_LIMIT)) begin
         n_enabled = COUNT_W'(ENABLE_LIMIT);
      end else begin
         n_enabled = count_ff;
      end
   end

   // Present every server to the arg-min tree and mark the enabled ones.
   always_comb begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
         leaf[i].valid     = (i < int'(n_enabled));
         leaf[i].index     = SRV_IDX_W'(i);
         leaf[i].task_time = time_ff[i];
         leaf[i].tasks     = tasks_ff[i];
         leaf[i].finish    = finish_ff[i];
      end
   end

   mftd_argmin u_argmin (
      .leaf   (leaf),
      .winner (winner)
   );

   // Decode the request in the input register.
   assign is_load    = (stage_mode_ff == MODE_LOAD);
   assign load_hit   = (int'(stage_index_ff) < MAX_SERVERS);
   assign load_slot  = SRV_IDX_W'(stage_index_ff);
   assign has_result = !is_load && winner.valid;

   // Only a request that yields a response has to wait for the output register.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && (!has_result || out_free);
   assign req_stall = stage_valid_ff && !advance;

   // The stored finish equals (count+1)*time. When the count moves up, it is the new finish,
   // and the next one is one task time further. A saturated count keeps its finish, and the
   // report is one task time less.
   assign saturated = (winner.tasks == TASK_MAX);
   always_comb begin
      if (saturated) begin
         count_in      = winner.tasks;
         finish_in     = winner.finish;
         report_finish = winner.finish - FINISH_W'(winner.task_time);
      end else begin
         count_in      = winner.tasks + TASKS_W'(1);
         finish_in     = winner.finish + FINISH_W'(winner.task_time);
         report_finish = winner.finish;
      end
   end

   // Next state of the input register.
   assign stage_valid_in = req_stall ? stage_valid_ff : req_valid;

   // Next state of the output register.
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_server_in = out_server_ff;
      out_total_in  = out_total_ff;
      out_finish_in = out_finish_ff;
      if (advance && has_result) begin
         out_valid_in  = 1'b1;
         out_server_in = INDEX_W'(winner.index);
         out_total_in  = count_in;
         out_finish_in = report_finish;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= COUNT_RESET;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= csr_server_count;
         end
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         stage_mode_ff  <= req_mode;
         stage_index_ff <= req_server_index;
         stage_time_ff  <= req_task_time;
      end
      out_server_ff <= out_server_in;
      out_total_ff  <= out_total_in;
      out_finish_ff <= out_finish_in;
   end

   // Task counts: reset to zero, cleared by a load, stepped by an assignment.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            tasks_ff[i] <= '0;
         end
      end else if (advance) begin
         if (is_load && load_hit) begin
            tasks_ff[load_slot] <= '0;
         end else if (has_result) begin
            tasks_ff[winner.index] <= count_in;
         end
      end
   end

   // Task times and next finish times are undefined until a load request writes them.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (is_load && load_hit) begin
            time_ff[load_slot]   <= stage_time_ff;
            finish_ff[load_slot] <= FINISH_W'(stage_time_ff);
         end else if (has_result) begin
            finish_ff[winner.index] <= finish_in;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_chosen_server = out_server_ff;
   assign rsp_task_total    = out_total_ff;
   assign rsp_finish_time   = out_finish_ff;

   // A reported server is always one of the enabled servers.
   a_server_enabled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (int'(out_server_ff) < int'(n_enabled)))
      else $error("reported server is not enabled");

   // A reported count includes the current task, so it is never zero.
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_total_ff != '0))
      else $error("reported task count is zero");

   // An assignment never moves forward while a response is held back.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result) |-> out_free)
      else $error("response register overwritten while stalled");

   // A request held in the input register stays there until it moves forward.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> (stage_valid_ff && $stable(stage_mode_ff) && $stable(stage_index_ff)))
      else $error("input register lost a stalled request");

endmodule

`default_nettype wire

// ===== sim/tb_min_finish_task_dispatcher.sv =====
// Self-checking testbench for the minimum-finish task dispatcher under random flow control.
`timescale 1ns / 100ps

module tb_min_finish_task_dispatcher
   import mftd_pkg::*;
();

   // One request as the sender offers it.
   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0]  task_time;
   } dispatch_req_type;

   // One assignment that the block owes.
   typedef struct {
      logic [INDEX_W-1:0]  server;
      logic [TASKS_W-1:0]  total;
      logic [FINISH_W-1:0] finish;
   } assignment_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_server_count = COUNT_RESET;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = MODE_LOAD;
   logic [INDEX_W-1:0]  req_server_index = '0;
   logic [TIME_W-1:0]   req_task_time = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_chosen_server;
   logic [TASKS_W-1:0]  rsp_task_total;
   logic [FINISH_W-1:0] rsp_finish_time;

   // Requests waiting to be offered and assignments waiting to come back.
   dispatch_req_type request_q[$];
   assignment_type   assignment_q[$];

   // Shadow copy of the dispatcher state.
   logic [COUNT_W-1:0]  srv_count;
   logic [TIME_W-1:0]   srv_time [MAX_SERVERS];
   logic [TASKS_W-1:0]  srv_tasks [MAX_SERVERS];
   logic [FINISH_W-1:0] srv_next [MAX_SERVERS];

   int fail_count = 0;

   // Flow control knobs shared between the sequence and the two sides.
   logic sender_hold = 1'b0;
   logic steady = 1'b0;
   int   hold_request = 0;

   // Sender state.
   dispatch_req_type cur_req;
   int burst_left = 0;
   int gap_left = 0;

   // Receiver state.
   int hold_taken = 0;
   int hold_left = 0;
   int pattern_left = 0;
   int stall_pct = 0;

   int load_times [8] = '{4, 4, 65535, 2, 3, 8, 1, 6};
   int phase_counts [12] = '{8, 1, 5, 0, 3, 12, 2, 7, 4, 15, 6, 8};

   min_finish_task_dispatcher u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_server_count  (csr_server_count),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_server_index  (req_server_index),
      .req_task_time     (req_task_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chosen_server (rsp_chosen_server),
      .rsp_task_total    (rsp_task_total),
      .rsp_finish_time   (rsp_finish_time)
   );

   always #10 clock = ~clock;

   // Apply one accepted request to the shadow state and record the assignment it causes.
   function automatic void greedy_dispatch(input dispatch_req_type r);
      int unsigned        enabled;
      int unsigned        pick;
      int unsigned        k;
      logic [TASKS_W-1:0] tally;
      assignment_type     owed;
      if (r.mode == MODE_LOAD) begin
         if (r.index < MAX_SERVERS) begin
            srv_time[r.index] = r.task_time;
            srv_tasks[r.index] = '0;
            srv_next[r.index] = FINISH_W'(r.task_time);
         end
         return;
      end
      enabled = (srv_count > ENABLE_LIMIT) ? ENABLE_LIMIT : srv_count;
      if (enabled == 0) return;
      // Least finish time wins, then the smaller task time, then the lower index.
      pick = 0;
      for (k = 1; k < enabled; k++) begin
         if (srv_next[k] < srv_next[pick] ||
             (srv_next[k] == srv_next[pick] && srv_time[k] < srv_time[pick]))
            pick = k;
      end
      tally = srv_tasks[pick];
      if (tally != TASK_MAX) tally = tally + 1'b1;
      srv_tasks[pick] = tally;
      srv_next[pick] = (FINISH_W'(tally) + 1) * FINISH_W'(srv_time[pick]);
      owed.server = INDEX_W'(pick);
      owed.total = tally;
      owed.finish = FINISH_W'(tally) * FINISH_W'(srv_time[pick]);
      assignment_q = {assignment_q, owed};
   endfunction

   // Task times lean small so that ties between servers are common.
   function automatic logic [TIME_W-1:0] rand_task_time();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return '0;
      if (roll < 55) return TIME_W'($urandom_range(1, 8));
      if (roll < 80) return TIME_W'($urandom_range(1, 400));
      return TIME_W'($urandom);
   endfunction

   task automatic queue_request(input logic [MODE_W-1:0] mode, input int index,
                                input int unsigned t);
      dispatch_req_type r;
      r.mode = mode;
      r.index = INDEX_W'(index);
      r.task_time = TIME_W'(t);
      request_q = {request_q, r};
   endtask

   // Mostly assignments, with loads aimed mainly at the enabled servers.
   task automatic queue_random(input int n, input int enabled);
      int k;
      int idx;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            if (enabled > 0 && $urandom_range(0, 4) != 0) idx = $urandom_range(0, enabled - 1);
            else idx = $urandom_range(0, 7);
            queue_request(MODE_LOAD, idx, rand_task_time());
         end else begin
            queue_request(MODE_ASSIGN, $urandom_range(0, 7), $urandom);
         end
      end
   endtask

   // Wait for every request to be taken and every assignment to return, then let loads settle.
   task automatic drain_all();
      do @(negedge clock); while (request_q.size() != 0 || req_valid || assignment_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_server_count(input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_server_count <= COUNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      srv_count = COUNT_W'(value);
      @(negedge clock);
   endtask

   // Sender: bursts of requests with random gaps; a stalled request is held as it is.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 40);
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) greedy_dispatch(cur_req);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 && !steady) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_q.size() != 0 && !sender_hold) begin
               cur_req = request_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= cur_req.mode;
               req_server_index <= cur_req.index;
               req_task_time <= cur_req.task_time;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: compare each response with the oldest owed assignment, then pick the next stall.
   always @(posedge clock) begin
      assignment_type owed;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (assignment_q.size() == 0) begin
               if (fail_count < 10)
                  $display("Response server %0d total %0d finish %0d with nothing owed",
                           rsp_chosen_server, rsp_task_total, rsp_finish_time);
               fail_count++;
            end else begin
               owed = assignment_q.pop_front();
               if (rsp_chosen_server !== owed.server || rsp_task_total !== owed.total ||
                   rsp_finish_time !== owed.finish) begin
                  if (fail_count < 10)
                     $display("Mismatch: expected server %0d total %0d finish %0d, %s %0d %0d %0d",
                              owed.server, owed.total, owed.finish, "got",
                              rsp_chosen_server, rsp_task_total, rsp_finish_time);
                  fail_count++;
               end
            end
         end
         // A long hold-off when asked for, otherwise stall odds redrawn at the end of each random-length pattern.
         if (hold_taken != hold_request) begin
            hold_taken = hold_request;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            if (pattern_left <= 0) begin
               pattern_left = $urandom_range(16, 96);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            pattern_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Request sequence: directed cases, random phases over several server counts, a steady run.
   initial begin
      int ph;
      int k;
      int enabled;
      srv_count = COUNT_RESET;
      for (k = 0; k < MAX_SERVERS; k++) begin
         srv_time[k] = '0;
         srv_tasks[k] = '0;
         srv_next[k] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Load every server first so that no assignment ever reads an unwritten time.
      // Servers 0 and 1 share a time, so the first assignments tie down to the index.
      for (k = 0; k < 8; k++) queue_request(MODE_LOAD, k, load_times[k]);
      repeat (3) queue_request(MODE_ASSIGN, 7, 65535);
      drain_all();
      write_server_count(8);
      repeat (5) queue_request(MODE_ASSIGN, 0, 0);
      drain_all();
      // A count above eight acts as eight.
      write_server_count(15);
      repeat (2) queue_request(MODE_ASSIGN, 5, 1);
      drain_all();
      // With no servers enabled an assignment gives no response.
      write_server_count(0);
      repeat (2) queue_request(MODE_ASSIGN, 2, 2);
      drain_all();
      // A zero task time gives a zero finish that wins every comparison.
      write_server_count(3);
      queue_request(MODE_LOAD, 2, 0);
      repeat (2) queue_request(MODE_ASSIGN, 3, 3);
      queue_request(MODE_LOAD, 2, 65535);
      queue_request(MODE_ASSIGN, 4, 4);
      drain_all();

      for (ph = 0; ph < 12; ph++) begin
         write_server_count(phase_counts[ph]);
         enabled = (phase_counts[ph] > ENABLE_LIMIT) ? ENABLE_LIMIT : phase_counts[ph];
         if (ph == 0) hold_request++;
         if (ph == 4) begin
            // Sender pauses until every owed assignment has come back.
            queue_random(72, enabled);
            while (request_q.size() != 0) @(negedge clock);
            sender_hold = 1'b1;
            queue_random(72, enabled);
            do @(negedge clock); while (req_valid || assignment_q.size() != 0);
            repeat (3) @(negedge clock);
            sender_hold = 1'b0;
         end else begin
            queue_random(144, enabled);
         end
         drain_all();
      end

      // One server taking tasks back to back without stalls, then a reload that clears it.
      steady = 1'b1;
      write_server_count(1);
      queue_request(MODE_LOAD, 0, 65535);
      for (k = 0; k < 40; k++) queue_request(MODE_ASSIGN, k % 8, k);
      drain_all();
      queue_request(MODE_LOAD, 0, 3);
      repeat (2) queue_request(MODE_ASSIGN, 1, 9);
      drain_all();
      steady = 1'b0;

      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog for a block that stops responding.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mftd_pkg.sv
sv/mftd_argmin.sv
sv/min_finish_task_dispatcher.sv
sim/tb_min_finish_task_dispatcher.sv
